// File: design/erf_pkg.sv
package erf_pkg;

	// default width of the echo tick counter
	localparam int CountWidthDef = 16;

	// frames that may be in flight between the counter and the character output;
	// keep a power of two so the queue pointers wrap on their own
	localparam int FrameDepth = 4;

	localparam logic [7:0] ScaleReset = 8'd17;

	// products at or above this give a distance over 999 cm
	localparam int ProdLimit = 100000;
	localparam int ClipWidth = 17;

	// floor(x / 100) = (x * RecipHund) >> RecipShift for x below 100000
	localparam int RecipShift = 24;
	localparam int RecipWidth = 18;
	localparam logic [RecipWidth-1:0] RecipHund = 18'd167773;
	localparam int DistWidth = 10;

	// ASCII codes of the frame
	localparam logic [7:0] CharHome  = 8'd17;
	localparam logic [7:0] CharZero  = 8'h30;
	localparam logic [7:0] CharSpace = 8'h20;
	localparam logic [7:0] CharC     = 8'h63;
	localparam logic [7:0] CharM     = 8'h6d;

	// character positions within a frame
	localparam logic [2:0] IdxHome  = 3'd0;
	localparam logic [2:0] IdxHund  = 3'd1;
	localparam logic [2:0] IdxTens  = 3'd2;
	localparam logic [2:0] IdxUnits = 3'd3;
	localparam logic [2:0] IdxSpace = 3'd4;
	localparam logic [2:0] IdxC     = 3'd5;
	localparam logic [2:0] IdxM     = 3'd6;

	typedef struct packed {
		logic [3:0] hund;
		logic [3:0] tens;
		logic [3:0] units;
	} digits_t;

	function automatic logic [7:0] frame_char(input logic [2:0] idx, input digits_t dg);
		logic [7:0] ch;
		unique case (idx)
			IdxHome:  ch = CharHome;
			IdxHund:  ch = CharZero + {4'd0, dg.hund};
			IdxTens:  ch = CharZero + {4'd0, dg.tens};
			IdxUnits: ch = CharZero + {4'd0, dg.units};
			IdxSpace: ch = CharSpace;
			IdxC:     ch = CharC;
			IdxM:     ch = CharM;
			default:  ch = CharHome;
		endcase
		return ch;
	endfunction

endpackage

// File: design/erf_ranger.sv
module erf_ranger import erf_pkg::*; #(
	parameter int CountWidth = CountWidthDef
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  tick_valid,
	input  logic                  echo_level,
	output logic                  tick_stall,
	input  logic                  frame_pop,
	output logic                  cap_vld_s1,
	output logic [CountWidth-1:0] cap_count_s1
);

	localparam int OutW = $clog2(FrameDepth + 1);

	logic                  counting_q;
	logic [CountWidth-1:0] tick_count_q;
	logic [OutW-1:0]       outstanding_q;
	logic                  take;
	logic                  frame_take;
	logic                  credit_full;

	assign credit_full = (outstanding_q == OutW'(FrameDepth));
	// hold only a falling edge that has no room downstream
	assign tick_stall  = credit_full && counting_q && !echo_level;
	assign take        = tick_valid && !tick_stall;
	assign frame_take  = take && counting_q && !echo_level;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counting_q    <= 1'b0;
			tick_count_q  <= '0;
			cap_vld_s1    <= 1'b0;
			outstanding_q <= '0;
		end else begin
			cap_vld_s1 <= frame_take;
			if (take) begin
				if (echo_level) begin
					if (!counting_q) begin
						counting_q   <= 1'b1;
						tick_count_q <= CountWidth'(1);
					end else if (tick_count_q != '1) begin
						tick_count_q <= tick_count_q + CountWidth'(1);
					end
				end else if (counting_q) begin
					counting_q   <= 1'b0;
					tick_count_q <= '0;
				end
			end
			unique case ({frame_take, frame_pop})
				2'b10:   outstanding_q <= outstanding_q + OutW'(1);
				2'b01:   outstanding_q <= outstanding_q - OutW'(1);
				default: outstanding_q <= outstanding_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (frame_take) begin
			cap_count_s1 <= tick_count_q;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		outstanding_q <= OutW'(FrameDepth))
		else $error("frame credit count above queue depth");

endmodule

// File: design/erf_scaler.sv
module erf_scaler import erf_pkg::*; #(
	parameter int CountWidth = CountWidthDef
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cap_vld_s1,
	input  logic [CountWidth-1:0] cap_count_s1,
	input  logic [7:0]            scale_hundredths,
	output logic                  dig_vld,
	output digits_t               digits
);

	localparam int ProdW = CountWidth + 8;
	localparam int ExtW  = (ProdW > ClipWidth) ? ProdW : ClipWidth;
	localparam int QuotW = ClipWidth + RecipWidth;

	logic                 vld_s2;
	logic                 vld_s3;
	logic [ProdW-1:0]     prod_s2;
	logic [DistWidth-1:0] dist_s3;
	logic [ExtW-1:0]      prod_ext;
	logic [ClipWidth-1:0] clip;
	logic [QuotW-1:0]     quot;
	logic [15:0]          hund_full;
	logic [3:0]           hund;
	logic [DistWidth-1:0] rem_full;
	logic [6:0]           rem;
	logic [15:0]          tens_full;
	logic [3:0]           tens;
	logic [6:0]           units_full;

	// clamp the product so the quotient stays at or below 999
	assign prod_ext = ExtW'(prod_s2);
	assign clip     = (prod_ext >= ExtW'(ProdLimit)) ? ClipWidth'(ProdLimit - 1)
	                                                 : prod_ext[ClipWidth-1:0];
	assign quot     = QuotW'(clip) * QuotW'(RecipHund);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s2 <= cap_vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= ProdW'(cap_count_s1) * ProdW'(scale_hundredths);
		dist_s3 <= quot[RecipShift +: DistWidth];
	end

	// split 0..999 into decimal digits by reciprocal multiplies
	assign hund_full  = 16'(dist_s3) * 16'd41;
	assign hund       = hund_full[12 +: 4];
	assign rem_full   = dist_s3 - DistWidth'(hund) * DistWidth'(100);
	assign rem        = rem_full[6:0];
	assign tens_full  = 16'(rem) * 16'd205;
	assign tens       = tens_full[11 +: 4];
	assign units_full = rem - 7'(tens) * 7'd10;

	assign dig_vld      = vld_s3;
	assign digits.hund  = hund;
	assign digits.tens  = tens;
	assign digits.units = units_full[3:0];

endmodule

// File: design/erf_framer.sv
module erf_framer import erf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       dig_vld,
	input  digits_t    digits,
	output logic       frame_pop,
	output logic       tx_valid,
	input  logic       tx_stall,
	output logic [7:0] tx_char,
	output logic       frame_last
);

	localparam int PtrW = $clog2(FrameDepth);
	localparam int CntW = $clog2(FrameDepth + 1);

	digits_t         fifo_mem [FrameDepth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] fifo_cnt_q;
	logic            busy_q;
	logic [2:0]      idx_q;
	digits_t         cur_q;
	logic            tx_valid_q;
	logic [7:0]      tx_char_q;
	logic            tx_last_q;
	logic            load_en;
	logic            fifo_empty;

	assign fifo_empty = (fifo_cnt_q == '0);
	assign load_en    = !tx_valid_q || !tx_stall;
	assign frame_pop  = load_en && !busy_q && !fifo_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			fifo_cnt_q <= '0;
			busy_q     <= 1'b0;
			idx_q      <= IdxHome;
			tx_valid_q <= 1'b0;
		end else begin
			if (dig_vld) begin
				wr_ptr_q <= wr_ptr_q + PtrW'(1);
			end
			if (frame_pop) begin
				rd_ptr_q <= rd_ptr_q + PtrW'(1);
			end
			unique case ({dig_vld, frame_pop})
				2'b10:   fifo_cnt_q <= fifo_cnt_q + CntW'(1);
				2'b01:   fifo_cnt_q <= fifo_cnt_q - CntW'(1);
				default: fifo_cnt_q <= fifo_cnt_q;
			endcase
			if (load_en) begin
				priority if (busy_q) begin
					tx_valid_q <= 1'b1;
					if (idx_q == IdxM) begin
						busy_q <= 1'b0;
					end else begin
						idx_q <= idx_q + 3'd1;
					end
				end else if (!fifo_empty) begin
					tx_valid_q <= 1'b1;
					busy_q     <= 1'b1;
					idx_q      <= IdxHund;
				end else begin
					tx_valid_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (dig_vld) begin
			fifo_mem[wr_ptr_q] <= digits;
		end
		if (load_en) begin
			if (busy_q) begin
				tx_char_q <= frame_char(idx_q, cur_q);
				tx_last_q <= (idx_q == IdxM);
			end else if (!fifo_empty) begin
				cur_q     <= fifo_mem[rd_ptr_q];
				tx_char_q <= CharHome;
				tx_last_q <= 1'b0;
			end
		end
	end

	assign tx_valid   = tx_valid_q;
	assign tx_char    = tx_char_q;
	assign frame_last = tx_last_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		fifo_cnt_q <= CntW'(FrameDepth))
		else $error("frame queue overflow");

	assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> tx_valid_q)
		else $error("frame in progress without a character on show");

	assert property (@(posedge clk) disable iff (!arst_n)
		(tx_valid_q && tx_last_q) |-> !busy_q)
		else $error("last character shown while frame still in progress");

endmodule

// File: design/echo_range_to_ascii_frame.sv
// Path: ranger capture, scaler product and quotient, frame queue, output register.
// Throughput: one tick per cycle unless held; one character per cycle unless tx_stall.
// Up to four frames queue between the counter and the character output; a falling edge
// is held only while all four are taken, other ticks are never held.
// Reset (arst_n low, asynchronous): counter idle and cleared, queue empty, no character
// shown, scale back to 17 hundredths of a centimetre per tick.
module echo_range_to_ascii_frame import erf_pkg::*; #(
	parameter int CountWidth = CountWidthDef
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [7:0] cfg_wr_data,
	input  logic       tick_valid,
	output logic       tick_stall,
	input  logic       echo_level,
	output logic       tx_valid,
	input  logic       tx_stall,
	output logic [7:0] tx_char,
	output logic       frame_last
);

	logic [7:0]            scale_q;
	logic                  cap_vld_s1;
	logic [CountWidth-1:0] cap_count_s1;
	logic                  dig_vld;
	digits_t               digits;
	logic                  frame_pop;

	// scale register: the user must write it only while the block is idle, so the
	// pipeline sees one steady value for every frame in flight; the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= ScaleReset;
		end else if (cfg_wr_en) begin
			scale_q <= cfg_wr_data;
		end
	end

	// pulse-width counter; captures the count on the falling edge and
	// keeps the frame credit that throttles the tick transfer
	erf_ranger #(
		.CountWidth(CountWidth)
	) u_ranger (
		.clk         (clk),
		.arst_n      (arst_n),
		.tick_valid  (tick_valid),
		.echo_level  (echo_level),
		.tick_stall  (tick_stall),
		.frame_pop   (frame_pop),
		.cap_vld_s1  (cap_vld_s1),
		.cap_count_s1(cap_count_s1)
	);

	// count times scale, divide by one hundred, clamp to 999, split to digits
	erf_scaler #(
		.CountWidth(CountWidth)
	) u_scaler (
		.clk             (clk),
		.arst_n          (arst_n),
		.cap_vld_s1      (cap_vld_s1),
		.cap_count_s1    (cap_count_s1),
		.scale_hundredths(scale_q),
		.dig_vld         (dig_vld),
		.digits          (digits)
	);

	// queue the digits and serialise the seven-character frame
	erf_framer u_framer (
		.clk       (clk),
		.arst_n    (arst_n),
		.dig_vld   (dig_vld),
		.digits    (digits),
		.frame_pop (frame_pop),
		.tx_valid  (tx_valid),
		.tx_stall  (tx_stall),
		.tx_char   (tx_char),
		.frame_last(frame_last)
	);

endmodule

// File: tb/echo_range_to_ascii_frame_tb.sv
module echo_range_to_ascii_frame_tb;

	// characters of a distance frame
	localparam logic [7:0] CHAR_HOME  = 8'd17;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_C     = 8'h63;
	localparam logic [7:0] CHAR_M     = 8'h6d;

	localparam int unsigned DIST_CLAMP  = 999;
	localparam logic [7:0]  SCALE_RESET = 8'd17;

	localparam int WATCHDOG_LIMIT = 4000; // cycles without any transfer
	localparam int HOLD_CYCLES    = 300;  // long receiver hold-off
	localparam int SETTLE_CYCLES  = 10;   // let the pipeline empty before a register write
	localparam int TAIL_CYCLES    = 20;   // quiet time after the last character
	localparam int RANDOM_TICKS   = 15;   // per idling phase
	localparam int REPORT_LIMIT   = 10;

	typedef enum logic [1:0] {
		IDLE_NONE,
		IDLE_SEND,
		IDLE_RECV,
		IDLE_BOTH
	} idle_mode_e;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} frame_char_t;

	logic       clk;
	logic       arst_n;
	logic       cfg_wr_en;
	logic [7:0] cfg_wr_data;
	logic       tick_valid;
	logic       tick_stall;
	logic       echo_level;
	logic       tx_valid;
	logic       tx_stall;
	logic [7:0] tx_char;
	logic       frame_last;

	echo_range_to_ascii_frame dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.tick_valid  (tick_valid),
		.tick_stall  (tick_stall),
		.echo_level  (echo_level),
		.tx_valid    (tx_valid),
		.tx_stall    (tx_stall),
		.tx_char     (tx_char),
		.frame_last  (frame_last)
	);

	// ranging state as the block should hold it
	logic        meas_active = 1'b0;
	logic [15:0] echo_ticks  = '0;
	logic [7:0]  scale_cfg   = SCALE_RESET;

	frame_char_t expected_chars[$];
	int          chars_owed = 0;   // characters predicted but not yet seen

	int          fail_count     = 0;
	int          mismatch_count = 0;
	int          stalled_cycles = 0;

	// sender side
	int          send_idle_pct  = 0;
	int          ticks_sent     = 0;
	logic        line_high      = 1'b0; // level of the last tick transferred

	// receiver side
	int          recv_stall_pct = 0;
	logic        hold_req       = 1'b0;
	int          hold_left      = 0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Prediction: one echo tick in, a full frame out on the falling edge
	// ------------------------------------------------------------------
	task automatic push_frame_char(input logic [7:0] ch, input logic last);
		frame_char_t fc;
		fc.ch   = ch;
		fc.last = last;
		expected_chars.push_back(fc);
		chars_owed++;
	endtask

	task automatic predict_echo_tick(input logic lvl);
		logic [23:0] product;
		int unsigned dist_cm;
		if (lvl) begin
			// rising edge starts at one, further high ticks count up to saturation
			if (!meas_active) begin
				meas_active = 1'b1;
				echo_ticks  = 16'd1;
			end else if (echo_ticks != 16'hffff) begin
				echo_ticks++;
			end
		end else if (meas_active) begin
			product = echo_ticks * scale_cfg;
			dist_cm = product / 100;
			if (dist_cm > DIST_CLAMP)
				dist_cm = DIST_CLAMP;
			push_frame_char(CHAR_HOME, 1'b0);
			push_frame_char(CHAR_ZERO + 8'((dist_cm / 100) % 10), 1'b0);
			push_frame_char(CHAR_ZERO + 8'((dist_cm / 10) % 10), 1'b0);
			push_frame_char(CHAR_ZERO + 8'(dist_cm % 10), 1'b0);
			push_frame_char(CHAR_SPACE, 1'b0);
			push_frame_char(CHAR_C, 1'b0);
			push_frame_char(CHAR_M, 1'b1);
			meas_active = 1'b0;
			echo_ticks  = '0;
		end
	endtask

	task automatic check_frame_char(input logic [7:0] ch, input logic last);
		frame_char_t exp_fc;
		if (expected_chars.size() == 0) begin
			fail_count++;
			mismatch_count++;
			if (mismatch_count <= REPORT_LIMIT)
				$display("unexpected character: tx_char=%h frame_last=%b", ch, last);
		end else begin
			exp_fc = expected_chars.pop_front();
			chars_owed--;
			if (exp_fc.ch !== ch || exp_fc.last !== last) begin
				fail_count++;
				mismatch_count++;
				if (mismatch_count <= REPORT_LIMIT)
					$display("character mismatch: tx_char exp %h got %h, frame_last exp %b got %b",
						exp_fc.ch, ch, exp_fc.last, last);
			end
		end
	endtask

	// Sample both channels at the edge that completes each transfer; ticks are
	// predicted before characters are checked.
	always @(posedge clk) begin
		if (arst_n) begin
			if (tick_valid && !tick_stall)
				predict_echo_tick(echo_level);
			if (tx_valid && !tx_stall)
				check_frame_char(tx_char, frame_last);
		end
	end

	// Watchdog: abandon the run once nothing has moved for too long.
	always @(posedge clk) begin
		if ((tick_valid && !tick_stall) || (tx_valid && !tx_stall)) begin
			stalled_cycles <= 0;
		end else begin
			stalled_cycles <= stalled_cycles + 1;
			if (stalled_cycles == WATCHDOG_LIMIT) begin
				$display("echo_range_to_ascii_frame regression: fail");
				$finish;
			end
		end
	end

	// Receiver: random stalls, or a long hold-off when one is requested.
	initial begin
		tx_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req  <= 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				tx_stall <= 1'b1;
			end else begin
				tx_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	// ------------------------------------------------------------------
	// Sender helpers
	// ------------------------------------------------------------------

	// Offer one tick and return at the edge where it is transferred. Valid is
	// only lowered when a gap is taken, so back-to-back ticks keep it high.
	task automatic send_tick(input logic lvl);
		if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			tick_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
		tick_valid <= 1'b1;
		echo_level <= lvl;
		do
			@(posedge clk);
		while (tick_stall);
		line_high = lvl;
		ticks_sent++;
	endtask

	task automatic send_pulse(input int high_len, input int low_len);
		repeat (high_len) send_tick(1'b1);
		repeat (low_len) send_tick(1'b0);
	endtask

	// Hold the sender off until every predicted character has been seen.
	task automatic wait_frames_drained();
		tick_valid <= 1'b0;
		@(posedge clk);
		wait (chars_owed == 0);
	endtask

	task automatic set_idle_mode(input idle_mode_e mode);
		case (mode)
			IDLE_SEND: begin
				send_idle_pct  = 83;
				recv_stall_pct <= 0;
			end
			IDLE_RECV: begin
				send_idle_pct  = 0;
				recv_stall_pct <= 83;
			end
			IDLE_BOTH: begin
				send_idle_pct  = 16;
				recv_stall_pct <= 16;
			end
			default: begin
				send_idle_pct  = 0;
				recv_stall_pct <= 0;
			end
		endcase
	endtask

	// Write the scale only once the block is quiet: close any open pulse,
	// drain the frames, then give the pipeline time to settle.
	task automatic write_scale(input logic [7:0] value);
		if (line_high)
			send_tick(1'b0);
		wait_frames_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		scale_cfg = value;
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Reset scale: lows while waiting, shortest pulse, zero and small distances.
	task automatic test_frame_basics();
		set_idle_mode(IDLE_NONE);
		send_tick(1'b0);
		send_tick(1'b0);
		send_pulse(1, 1);   // 17/100 -> zero distance
		send_pulse(6, 2);   // 102/100 -> 1 cm, extra low ignored
		send_pulse(12, 1);  // 2 cm
		wait_frames_drained();
	endtask

	// Scale register at its extremes, zero included.
	task automatic test_scale_extremes();
		write_scale(8'd1);
		send_pulse(3, 1);   // well under 1 cm
		write_scale(8'd0);
		send_pulse(5, 1);   // always zero
		write_scale(8'd255);
		send_pulse(4, 1);   // 10 cm
	endtask

	// Distance past the 999 cm clamp.
	task automatic test_distance_clamp();
		write_scale(8'd255);
		send_pulse(393, 1); // 1002 cm -> clamped to 999 cm
	endtask

	// Fill the frame queue behind a long receiver hold-off, then let the
	// sender pause until the output has caught up.
	task automatic test_backpressure();
		write_scale(SCALE_RESET);
		set_idle_mode(IDLE_NONE);
		hold_req <= 1'b1;
		repeat (8) send_pulse($urandom_range(1, 4), 1);
		wait_frames_drained();
		send_pulse(10, 1);
		wait_frames_drained();
	endtask

	// Mostly well-formed pulses with random length and scale, some noise.
	task automatic run_random_phase(input idle_mode_e mode, input logic [7:0] scale);
		int start_ticks;
		int high_len;
		write_scale(scale);
		set_idle_mode(mode);
		start_ticks = ticks_sent;
		while (ticks_sent - start_ticks < RANDOM_TICKS) begin
			if ($urandom_range(9) < 8) begin
				if ($urandom_range(7) == 0)
					high_len = $urandom_range(13, 60);
				else
					high_len = $urandom_range(1, 12);
				send_pulse(high_len, $urandom_range(1, 3));
			end else begin
				repeat ($urandom_range(1, 4)) send_tick(1'($urandom_range(1)));
			end
			if ($urandom_range(14) == 0)
				wait_frames_drained();
		end
	endtask

	task automatic test_random_traffic();
		run_random_phase(IDLE_NONE, 8'($urandom_range(1, 255)));
		run_random_phase(IDLE_SEND, 8'd255);
		run_random_phase(IDLE_RECV, 8'($urandom_range(1, 255)));
		run_random_phase(IDLE_BOTH, 8'($urandom_range(1, 255)));
	endtask

	initial begin
		arst_n      = 1'b0;
		cfg_wr_en   = 1'b0;
		cfg_wr_data = '0;
		tick_valid  = 1'b0;
		echo_level  = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_frame_basics();
		test_scale_extremes();
		test_distance_clamp();
		test_backpressure();
		test_random_traffic();

		// close any open pulse, drain, then let the block settle
		if (line_high)
			send_tick(1'b0);
		wait_frames_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		fail_count += expected_chars.size();

		if (fail_count == 0)
			$display("echo_range_to_ascii_frame regression: pass");
		else
			$display("echo_range_to_ascii_frame regression: fail");
		$finish;
	end

endmodule

// File: echo_range_to_ascii_frame.f
design/erf_pkg.sv
design/erf_ranger.sv
design/erf_scaler.sv
design/erf_framer.sv
design/echo_range_to_ascii_frame.sv
tb/echo_range_to_ascii_frame_tb.sv
